// ----- sv/quadratic_root_solver_assert.svh -----
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// property must hold on every clock edge out of reset
`define QRS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// prop must hold in the cycle after cond (implication)
`define QRS_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- sv/qrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
   localparam int COEF_W   = 16;
   localparam int FRAC_W   = 16;
   localparam int ROOT_W   = 40;
   // discriminant magnitude fits in 2*COEF_W+2 bits, signed one more
   localparam int DISC_W   = 2 * COEF_W + 3;
   // square root result: integer part COEF_W+1 bits plus fraction
   localparam int SQRT_W   = COEF_W + 1 + FRAC_W;
   localparam int SQRT_N   = SQRT_W;
   // dividend: (-b*2^F +- s), divisor 2a
   localparam int NUM_W    = COEF_W + FRAC_W + 3;
   localparam int DEN_W    = COEF_W + 2;
   localparam int QUO_W    = NUM_W;
   localparam int DIV_N    = NUM_W;
   localparam int REM_W    = DEN_W + 1;

   // saturation bounds of the root fields
   localparam logic signed [63:0] ROOT_MAX_V = (64'sd1 <<< (ROOT_W - 1)) - 64'sd1;
   localparam logic signed [63:0] ROOT_MIN_V = -ROOT_MAX_V - 64'sd1;

   localparam logic [2:0] KIND_ALL    = 3'd0;
   localparam logic [2:0] KIND_NONE   = 3'd1;
   localparam logic [2:0] KIND_LINEAR = 3'd2;
   localparam logic [2:0] KIND_DOUBLE = 3'd3;
   localparam logic [2:0] KIND_TWO    = 3'd4;
   localparam logic [2:0] KIND_COMPLEX = 3'd5;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
   } req_type;

   typedef struct packed {
      logic [2:0]               kind;
      logic signed [ROOT_W-1:0] root_first;
      logic signed [ROOT_W-1:0] root_second;
   } rsp_type;

   // tag that rides with the equation down the chain
   typedef struct packed {
      logic [2:0]              kind;
      logic                    neg;  // quotient sign
      logic [NUM_W-1:0]        mag1;
      logic [NUM_W-1:0]        mag2;
      logic                    neg2;
      logic [DEN_W-1:0]        den;
   } tag_type;

   function automatic logic signed [ROOT_W-1:0] sat_root(input logic neg,
                                                         input logic [QUO_W-1:0] mag);
      logic signed [63:0] v;
      begin
         v = neg ? -$signed(64'(mag)) : $signed(64'(mag));
         if (v > ROOT_MAX_V)
            sat_root = ROOT_MAX_V[ROOT_W-1:0];
         else if (v < ROOT_MIN_V)
            sat_root = ROOT_MIN_V[ROOT_W-1:0];
         else
            sat_root = v[ROOT_W-1:0];
      end
   endfunction
endpackage
`default_nettype wire

// ----- sv/quadratic_root_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// quadratic root solver
// req channel carries one equation (coef_a, coef_b, coef_c) per transaction;
// rsp channel returns kind and the two roots in fixed point, one transaction
// for each request, in order.
// pipeline: 2 front stages (products, discriminant), SQRT_W = 33 square root
// cells, 1 setup stage, NUM_W = 35 divider cells and an output register:
// 72 register stages.
// throughput is one equation per cycle while the chain is not frozen; the
// whole chain advances together, so the length of the cell chains sets
// latency and not rate.
// the chain freezes and req_stall rises only while the output register
// holds a result (rsp_valid) and the receiver holds rsp_stall.
// synchronous reset empties every stage; no result is pending after it.
module quadratic_root_solver import qrs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
`include "quadratic_root_solver_assert.svh"

   logic enable;
   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   // stage 1: products
   logic                        s1_valid_ff;
   logic signed [2*COEF_W:0]    s1_bb_ff, s1_ac_ff;
   logic signed [COEF_W-1:0]    s1_a_ff, s1_b_ff, s1_c_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (enable) s1_valid_ff <= req_valid;
      if (enable) begin
         s1_bb_ff <= (2*COEF_W+1)'(req_data.coef_b * req_data.coef_b);
         s1_ac_ff <= (2*COEF_W+1)'(req_data.coef_a * req_data.coef_c);
         s1_a_ff  <= req_data.coef_a;
         s1_b_ff  <= req_data.coef_b;
         s1_c_ff  <= req_data.coef_c;
      end
   end

   // stage 2: discriminant and classification
   logic signed [DISC_W-1:0] disc;
   tag_type                  s2_tag;
   logic                     s2_do_sqrt;
   logic [NUM_W-1:0]         nb_mag;
   always_comb begin
      disc = DISC_W'(s1_bb_ff) - (DISC_W'(s1_ac_ff) <<< 2);
      s2_tag = '0;
      s2_do_sqrt = 1'b0;
      nb_mag = '0;
      if (s1_a_ff == '0 && s1_b_ff == '0) begin
         s2_tag.kind = (s1_c_ff == '0) ? KIND_ALL : KIND_NONE;
      end else if (s1_a_ff == '0) begin
         // -c/b: magnitude |c|<<F over |b|
         s2_tag.kind = KIND_LINEAR;
         s2_tag.mag1 = NUM_W'(s1_c_ff[COEF_W-1]
                              ? (COEF_W+1)'(-{s1_c_ff[COEF_W-1], s1_c_ff})
                              : {1'b0, s1_c_ff}) << FRAC_W;
         s2_tag.neg  = s1_c_ff[COEF_W-1] == s1_b_ff[COEF_W-1] && s1_c_ff != '0;
         s2_tag.den  = DEN_W'(s1_b_ff[COEF_W-1]
                              ? (COEF_W+1)'(-{s1_b_ff[COEF_W-1], s1_b_ff})
                              : {1'b0, s1_b_ff});
      end else if (disc < 0) begin
         s2_tag.kind = KIND_COMPLEX;
      end else begin
         s2_tag.kind = (disc == 0) ? KIND_DOUBLE : KIND_TWO;
         s2_do_sqrt  = disc != 0;
         // mag1 carries signed -b*2^F until the setup stage
         nb_mag = NUM_W'(-(NUM_W'(s1_b_ff) <<< FRAC_W));
         s2_tag.mag1 = nb_mag;
         s2_tag.neg  = s1_a_ff[COEF_W-1];
         s2_tag.den  = DEN_W'(s1_a_ff[COEF_W-1]
                              ? (COEF_W+1)'(-{s1_a_ff[COEF_W-1], s1_a_ff})
                              : {1'b0, s1_a_ff}) << 1;
      end
   end

   logic                s2_valid_ff;
   tag_type             s2_tag_ff;
   logic                s2_sq_ff;
   logic [2*SQRT_W-1:0] s2_rad_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (enable) s2_valid_ff <= s1_valid_ff;
      if (enable) begin
         s2_tag_ff <= s2_tag;
         s2_sq_ff  <= s2_do_sqrt;
         s2_rad_ff <= (2*SQRT_W)'(disc[DISC_W-2:0]) << (2*FRAC_W);
      end
   end

   // square root chain
   logic                valid_c [SQRT_N+1];
   logic [SQRT_W+1:0]   rem_c   [SQRT_N+1];
   logic [SQRT_W-1:0]   root_c  [SQRT_N+1];
   logic [2*SQRT_W-1:0] rest_c  [SQRT_N+1];
   tag_type             tag_c   [SQRT_N+1];
   logic                busy_c  [SQRT_N+1];
   assign valid_c[0] = s2_valid_ff;
   assign rem_c[0]   = '0;
   assign root_c[0]  = '0;
   assign rest_c[0]  = s2_rad_ff;
   assign tag_c[0]   = s2_tag_ff;
   assign busy_c[0]  = s2_sq_ff;

   for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
      qrs_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(valid_c[i]), .pair_in(rest_c[i][2*SQRT_W-1 -: 2]),
         .rem_in(rem_c[i]), .root_in(root_c[i]), .rest_in(rest_c[i]),
         .tag_in(tag_c[i]), .busy_in(busy_c[i]),
         .valid_out(valid_c[i+1]), .rem_out(rem_c[i+1]), .root_out(root_c[i+1]),
         .rest_out(rest_c[i+1]), .tag_out(tag_c[i+1]), .busy_out(busy_c[i+1])
      );
   end

   // setup: form both signed dividends, split into sign and magnitude
   tag_type                 st_tag;
   logic signed [NUM_W-1:0] n1, n2, sx;
   logic                    q1n, q2n;
   always_comb begin
      st_tag = tag_c[SQRT_N];
      sx = NUM_W'(root_c[SQRT_N]);
      n1 = $signed(st_tag.mag1) + sx;
      n2 = $signed(st_tag.mag1) - sx;
      q1n = n1[NUM_W-1] ^ st_tag.neg;
      q2n = n2[NUM_W-1] ^ st_tag.neg;
      st_tag.neg2 = 1'b0;
      if (st_tag.kind == KIND_DOUBLE || st_tag.kind == KIND_TWO) begin
         st_tag.mag1 = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
         st_tag.mag2 = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
         st_tag.neg  = q1n;
         st_tag.neg2 = q2n;
      end
      if (st_tag.den == '0) st_tag.den = DEN_W'(1);
   end

   logic             dvalid_c [DIV_N+1];
   tag_type          dtag_c   [DIV_N+1];
   logic [REM_W-1:0] r1_c     [DIV_N+1];
   logic [REM_W-1:0] r2_c     [DIV_N+1];
   logic             st_valid_ff;
   tag_type          st_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) st_valid_ff <= 1'b0;
      else if (enable) st_valid_ff <= valid_c[SQRT_N];
      if (enable) st_tag_ff <= st_tag;
   end
   assign dvalid_c[0] = st_valid_ff;
   assign dtag_c[0]   = st_tag_ff;
   assign r1_c[0]     = '0;
   assign r2_c[0]     = '0;

   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      qrs_div_cell u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(dvalid_c[j]), .tag_in(dtag_c[j]),
         .rem1_in(r1_c[j]), .rem2_in(r2_c[j]),
         .valid_out(dvalid_c[j+1]), .tag_out(dtag_c[j+1]),
         .rem1_out(r1_c[j+1]), .rem2_out(r2_c[j+1])
      );
   end

   // output register
   tag_type ot;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   always_comb begin
      ot = dtag_c[DIV_N];
      rsp_in = '0;
      rsp_in.kind = ot.kind;
      if (ot.kind == KIND_LINEAR || ot.kind == KIND_DOUBLE || ot.kind == KIND_TWO)
         rsp_in.root_first = sat_root(ot.neg, ot.mag1);
      if (ot.kind == KIND_TWO)
         rsp_in.root_second = sat_root(ot.neg2, ot.mag2);
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (enable) rsp_valid_ff <= dvalid_c[DIV_N];
      if (enable) rsp_data_ff <= rsp_in;
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `QRS_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data),
      "result changed while stalled")
   `QRS_ASSERT(a_kind, !rsp_valid || rsp_data.kind <= KIND_COMPLEX, "bad kind")
   `QRS_ASSERT(a_second, !rsp_valid || rsp_data.kind == KIND_TWO
      || rsp_data.root_second == '0, "second root must be zero")
endmodule
`default_nettype wire

// ----- sv/qrs_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// one digit of the restoring square root per cell
module qrs_sqrt_cell import qrs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              valid_in,
   input  wire logic [1:0]        pair_in,
   input  wire logic [SQRT_W+1:0] rem_in,
   input  wire logic [SQRT_W-1:0] root_in,
   input  wire logic [2*SQRT_W-1:0] rest_in,
   input  wire tag_type           tag_in,
   input  wire logic              busy_in,
   output logic                   valid_out,
   output logic [SQRT_W+1:0]      rem_out,
   output logic [SQRT_W-1:0]      root_out,
   output logic [2*SQRT_W-1:0]    rest_out,
   output tag_type                tag_out,
   output logic                   busy_out
);
   logic [SQRT_W+1:0] rem_sh;
   logic [SQRT_W+1:0] trial;
   logic              take;
   logic [SQRT_W+1:0] rem_in_v;
   logic [SQRT_W-1:0] root_in_v;
   logic              valid_ff;
   logic [SQRT_W+1:0] rem_ff;
   logic [SQRT_W-1:0] root_ff;
   logic [2*SQRT_W-1:0] rest_ff;
   tag_type           tag_ff;
   logic              busy_ff;

   always_comb begin
      rem_sh    = {rem_in[SQRT_W-1:0], pair_in};
      trial     = {root_in, 2'b01};
      take      = busy_in && (rem_sh >= trial);
      rem_in_v  = take ? rem_sh - trial : rem_sh;
      root_in_v = {root_in[SQRT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         rem_ff  <= rem_in_v;
         root_ff <= root_in_v;
         rest_ff <= {rest_in[2*SQRT_W-3:0], 2'b00};
         tag_ff  <= tag_in;
         busy_ff <= busy_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign rest_out  = rest_ff;
   assign tag_out   = tag_ff;
   assign busy_out  = busy_ff;
endmodule
`default_nettype wire

// ----- sv/qrs_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// one quotient bit for each of the two dividends per cell
module qrs_div_cell import qrs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire logic             valid_in,
   input  wire tag_type          tag_in,
   input  wire logic [REM_W-1:0] rem1_in,
   input  wire logic [REM_W-1:0] rem2_in,
   output logic                  valid_out,
   output tag_type               tag_out,
   output logic [REM_W-1:0]      rem1_out,
   output logic [REM_W-1:0]      rem2_out
);
   logic [REM_W-1:0] s1, s2, dext;
   logic             t1, t2;
   tag_type          tag_v;
   logic             valid_ff;
   tag_type          tag_ff;
   logic [REM_W-1:0] rem1_ff, rem2_ff;

   always_comb begin
      dext = {1'b0, tag_in.den};
      s1 = {rem1_in[REM_W-2:0], tag_in.mag1[NUM_W-1]};
      s2 = {rem2_in[REM_W-2:0], tag_in.mag2[NUM_W-1]};
      t1 = s1 >= dext;
      t2 = s2 >= dext;
      tag_v = tag_in;
      // dividend shifts out the top, quotient bits come in at the bottom
      tag_v.mag1 = {tag_in.mag1[NUM_W-2:0], t1};
      tag_v.mag2 = {tag_in.mag2[NUM_W-2:0], t2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         tag_ff  <= tag_v;
         rem1_ff <= t1 ? s1 - dext : s1;
         rem2_ff <= t2 ? s2 - dext : s2;
      end
   end

   assign valid_out = valid_ff;
   assign tag_out   = tag_ff;
   assign rem1_out  = rem1_ff;
   assign rem2_out  = rem2_ff;
endmodule
`default_nettype wire
